### rtl/time_to_collision_avoider_assert.svh
// assertion macros shared by the checker
`ifndef TIME_TO_COLLISION_AVOIDER_ASSERT_SVH
`define TIME_TO_COLLISION_AVOIDER_ASSERT_SVH

// consequence in the same cycle
`define TTCA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequence in the following cycle
`define TTCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ttca_pkg.sv
package ttca_pkg;

   localparam logic [1:0] VEH_SELF = 2'd0;
   localparam logic [1:0] VEH_NB1  = 2'd1;
   localparam logic [1:0] VEH_NB2  = 2'd2;

   localparam logic [2:0] CSR_TIME_THRESHOLD   = 3'd0;
   localparam logic [2:0] CSR_MINIMUM_DISTANCE = 3'd1;
   localparam logic [2:0] CSR_CRUISE_ALTITUDE  = 3'd2;
   localparam logic [2:0] CSR_BAND_HALF_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_VEHICLE_NUMBER   = 3'd4;
   localparam logic [2:0] CSR_AVOID_ENABLE     = 3'd5;

   localparam int ROT_STEPS  = 16;
   localparam int ROOT_STEPS = 30;
   localparam int DIV_STEPS  = 20;

   localparam logic [19:0] T_MAX = 20'hFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_GAIN_X,
      ST_GAIN_Y,
      ST_GAIN_W,
      ST_NB_CHECK,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_MUL_XV,
      ST_MUL_YV,
      ST_MUL_END,
      ST_ROOT,
      ST_JUDGE,
      ST_DIVIDE,
      ST_CHOOSE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic [15:0]        heading;
      logic signed [15:0] vel_fwd;
      logic signed [15:0] vel_side;
   } rot_cmd_type;

   typedef struct packed {
      logic root;
      logic div;
   } rd_cmd_type;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic signed [33:0] ttca_atan(input logic [3:0] i);
      logic signed [33:0] v;
      unique case (i)
         4'd0:  v = 34'sh020000000;
         4'd1:  v = 34'sh012E4051D;
         4'd2:  v = 34'sh009FB385B;
         4'd3:  v = 34'sh0051111D4;
         4'd4:  v = 34'sh0028B0D43;
         4'd5:  v = 34'sh00145D7E1;
         4'd6:  v = 34'sh000A2F61E;
         4'd7:  v = 34'sh000517C55;
         4'd8:  v = 34'sh00028BE53;
         4'd9:  v = 34'sh000145F2E;
         4'd10: v = 34'sh0000A2F98;
         4'd11: v = 34'sh0000517CC;
         4'd12: v = 34'sh000028BE6;
         4'd13: v = 34'sh0000145F3;
         4'd14: v = 34'sh00000A2F9;
         default: v = 34'sh00000517C;
      endcase
      return v;
   endfunction

endpackage

### rtl/ttca_cordic.sv
module ttca_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  ttca_pkg::rot_cmd_type    cmd,
   output logic                     done,
   output logic signed [32:0]       rot_x,
   output logic signed [32:0]       rot_y
);
   import ttca_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] xs, ys, xi, yi, ang;
   logic signed [15:0] hs;
   logic signed [16:0] zf;

   always_comb begin
      hs  = $signed(cmd.heading);
      xi  = {{4{cmd.vel_fwd[15]}}, cmd.vel_fwd, 14'b0};
      yi  = {{4{cmd.vel_side[15]}}, cmd.vel_side, 14'b0};
      zf  = {hs[15], hs};
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      ang = ttca_atan(cnt_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.start) begin
         // fold into the right half plane
         if (hs > 16'sd16384 || hs < -16'sd16384) begin
            xi = -xi;
            yi = -yi;
            zf = (hs > 16'sd0) ? zf - 17'sd32768 : zf + 17'sd32768;
         end
         x_in = xi;
         y_in = yi;
         z_in = {zf[16], zf, 16'b0};
         cnt_in = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 34'sd0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(ROT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done  = done_ff;
   assign rot_x = x_ff[32:0];
   assign rot_y = y_ff[32:0];

endmodule

### rtl/ttca_rootdiv.sv
module ttca_rootdiv (
   input  logic                  clock,
   input  logic                  reset,
   input  ttca_pkg::rd_cmd_type  cmd,
   input  logic [59:0]           radicand,
   input  logic [55:0]           divisor,
   output logic                  done,
   output logic [29:0]           root,
   output logic [19:0]           quot
);
   import ttca_pkg::*;

   logic        root_busy_ff, root_busy_in, div_busy_ff, div_busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [59:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic [74:0] rem_ff, rem_in, dv_ff, dv_in;
   logic [19:0] q_ff, q_in;

   always_comb begin
      trial        = r_ff + bit_ff;
      root_busy_in = root_busy_ff;
      div_busy_in  = div_busy_ff;
      done_in      = 1'b0;
      cnt_in = cnt_ff;
      v_in   = v_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      dv_in  = dv_ff;
      q_in   = q_ff;
      if (cmd.root) begin
         v_in   = radicand;
         r_in   = 60'd0;
         bit_in = {2'b01, 58'b0};
         cnt_in = 5'd0;
         root_busy_in = 1'b1;
      end else if (cmd.div) begin
         rem_in = {2'b00, radicand, 13'b0};
         dv_in  = {divisor, 19'b0};
         q_in   = 20'd0;
         cnt_in = 5'd0;
         div_busy_in = 1'b1;
      end else if (root_busy_ff) begin
         // one result bit per cycle
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_STEPS - 1)) begin
            root_busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_busy_ff) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = {q_ff[18:0], 1'b1};
         end else begin
            q_in   = {q_ff[18:0], 1'b0};
         end
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            div_busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_busy_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         root_busy_ff <= root_busy_in;
         div_busy_ff  <= div_busy_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign root = r_ff[29:0];
   assign quot = q_ff;

endmodule

### rtl/time_to_collision_avoider.sv
// a self request runs the 16-step rotation, 30-step square root and 20-step divider one after another,
// and may repeat them for the second neighbour
// neighbour and unused requests are taken while idle and give no response
// one request at a time; a finished response may wait while the next request is taken
// synchronous active-high reset restores the register defaults and clears neighbour poses
module time_to_collision_avoider (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_vehicle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [15:0]        req_heading,
   input  logic signed [15:0] req_vel_forward,
   input  logic signed [15:0] req_vel_side,
   input  logic signed [15:0] req_target_z,
   input  logic               req_mode_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [19:0]        rsp_time_to_hit,
   output logic               rsp_collide,
   output logic               rsp_shifted,
   output logic signed [15:0] rsp_cmd_z,
   output logic signed [15:0] rsp_climb_rate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data
);
   import ttca_pkg::*;

   state_type state_ff, state_in;

   logic [19:0]        thr_ff;
   logic [15:0]        mind_ff;
   logic signed [15:0] cruise_ff;
   logic [14:0]        band_ff;
   logic [2:0]         vnum_ff;
   logic               en_ff;

   logic signed [31:0] nb_x_ff [2];
   logic signed [31:0] nb_y_ff [2];
   logic [15:0]        nb_hd_ff [2];
   logic signed [15:0] nb_vf_ff [2];
   logic signed [15:0] nb_vs_ff [2];
   logic               seen_ff;

   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] tz_ff, tz_in;
   logic               mode_ff, mode_in, k_ff, k_in, phase_ff, phase_in;
   logic signed [23:0] swx_ff, swx_in, swy_ff, swy_in, nwx_ff, nwx_in, nwy_ff, nwy_in;
   logic signed [29:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [59:0]        d2_ff, d2_in;
   logic signed [55:0] dot_ff, dot_in;
   logic signed [65:0] prod_ff, product, rnd;
   logic [19:0]        t_ff, t_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_col_ff, rsp_col_in, rsp_sh_ff, rsp_sh_in;
   logic [19:0]        rsp_t_ff, rsp_t_in;
   logic signed [15:0] rsp_cz_ff, rsp_cz_in, rsp_cr_ff, rsp_cr_in;

   logic               nb_write;
   logic               nb_idx;

   rot_cmd_type        rot_cmd;
   logic               rot_done;
   logic signed [32:0] rot_x, rot_y;
   rd_cmd_type         rd_cmd;
   logic               rd_done;
   logic [29:0]        rd_root;
   logic [19:0]        rd_quot;

   logic signed [32:0] mul_a, mul_b, dx_full, dy_full;
   logic signed [24:0] vx, vy;
   logic               far;
   logic [55:0]        a_abs;
   logic [31:0]        m2;
   logic [61:0]        a25, s512;
   logic [62:0]        a128;
   logic [39:0]        t400;
   logic               moving, col;
   logic signed [17:0] tz18, lo18, hi18, cz18;
   logic [15:0]        cr16;

   ttca_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (rot_cmd),
      .done  (rot_done),
      .rot_x (rot_x),
      .rot_y (rot_y)
   );

   ttca_rootdiv u_rootdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rd_cmd),
      .radicand (d2_ff),
      .divisor  (a_abs),
      .done     (rd_done),
      .root     (rd_root),
      .quot     (rd_quot)
   );

   // datapath terms
   always_comb begin
      rnd     = (prod_ff + 66'sd33554432) >>> 26;
      dx_full = {nb_x_ff[k_ff][31], nb_x_ff[k_ff]} - {px_ff[31], px_ff};
      dy_full = {nb_y_ff[k_ff][31], nb_y_ff[k_ff]} - {py_ff[31], py_ff};
      far     = (dx_full >= 33'sd536870912) || (dx_full <= -33'sd536870912) ||
                (dy_full >= 33'sd536870912) || (dy_full <= -33'sd536870912);
      vx      = {nwx_ff[23], nwx_ff} - {swx_ff[23], swx_ff};
      vy      = {nwy_ff[23], nwy_ff} - {swy_ff[23], swy_ff};
      a_abs   = dot_ff[55] ? 56'(-dot_ff) : 56'(dot_ff);
      m2      = {16'b0, mind_ff} * {16'b0, mind_ff};
      a25     = {2'b0, a_abs, 4'b0} + {3'b0, a_abs, 3'b0} + {6'b0, a_abs};
      s512    = {23'b0, rd_root, 9'b0};
      a128    = {a_abs, 7'b0};
      t400    = {2'b0, rd_root, 8'b0} + {3'b0, rd_root, 7'b0} + {6'b0, rd_root, 4'b0};
      moving  = (a25 > s512) && (d2_ff > {28'b0, m2});
      col     = (t_ff < thr_ff) && en_ff;
      tz18    = {{2{tz_ff[15]}}, tz_ff};
      lo18    = {{2{cruise_ff[15]}}, cruise_ff} - $signed({3'b0, band_ff});
      hi18    = {{2{cruise_ff[15]}}, cruise_ff} + $signed({3'b0, band_ff});
      cz18    = tz18 - $signed({9'b0, vnum_ff, 6'b0}) + 18'sd128;
      cr16    = 16'd2560 - {13'b0, vnum_ff} * 16'd1280;
   end

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_GAIN_X: begin
            mul_a = rot_x;
            mul_b = 33'sd39797;
         end
         ST_GAIN_Y: begin
            mul_a = rot_y;
            mul_b = 33'sd39797;
         end
         ST_MUL_XX: begin
            mul_a = {{3{dx_ff[29]}}, dx_ff};
            mul_b = {{3{dx_ff[29]}}, dx_ff};
         end
         ST_MUL_YY: begin
            mul_a = {{3{dy_ff[29]}}, dy_ff};
            mul_b = {{3{dy_ff[29]}}, dy_ff};
         end
         ST_MUL_XV: begin
            mul_a = {{3{dx_ff[29]}}, dx_ff};
            mul_b = {{8{vx[24]}}, vx};
         end
         ST_MUL_YV: begin
            mul_a = {{3{dy_ff[29]}}, dy_ff};
            mul_b = {{8{vy[24]}}, vy};
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
      product = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      rot_cmd = '{start: 1'b0, heading: req_heading, vel_fwd: req_vel_forward,
                  vel_side: req_vel_side};
      rd_cmd  = '{root: 1'b0, div: 1'b0};
      nb_write = 1'b0;
      nb_idx   = 1'b0;
      px_in = px_ff;
      py_in = py_ff;
      tz_in = tz_ff;
      mode_in = mode_ff;
      k_in = k_ff;
      phase_in = phase_ff;
      swx_in = swx_ff;
      swy_in = swy_ff;
      nwx_in = nwx_ff;
      nwy_in = nwy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      d2_in = d2_ff;
      dot_in = dot_ff;
      t_in = t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_t_in  = rsp_t_ff;
      rsp_col_in = rsp_col_ff;
      rsp_sh_in = rsp_sh_ff;
      rsp_cz_in = rsp_cz_ff;
      rsp_cr_in = rsp_cr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_vehicle)
                  VEH_SELF: begin
                     px_in = req_pos_x;
                     py_in = req_pos_y;
                     tz_in = req_target_z;
                     mode_in = req_mode_ok;
                     k_in = 1'b0;
                     phase_in = 1'b0;
                     rot_cmd.start = 1'b1;
                     state_in = ST_ROTATE;
                  end
                  VEH_NB1: begin
                     nb_write = 1'b1;
                     nb_idx = 1'b0;
                  end
                  VEH_NB2: begin
                     nb_write = 1'b1;
                     nb_idx = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROTATE: if (rot_done) state_in = ST_GAIN_X;
         ST_GAIN_X: state_in = ST_GAIN_Y;
         ST_GAIN_Y: begin
            if (phase_ff) nwx_in = rnd[23:0];
            else swx_in = rnd[23:0];
            state_in = ST_GAIN_W;
         end
         ST_GAIN_W: begin
            if (phase_ff) begin
               nwy_in = rnd[23:0];
               state_in = ST_MUL_XX;
            end else begin
               swy_in = rnd[23:0];
               state_in = ST_NB_CHECK;
            end
         end
         ST_NB_CHECK: begin
            if (far) begin
               t_in = T_MAX;
               state_in = ST_CHOOSE;
            end else begin
               dx_in = dx_full[29:0];
               dy_in = dy_full[29:0];
               rot_cmd = '{start: 1'b1, heading: nb_hd_ff[k_ff], vel_fwd: nb_vf_ff[k_ff],
                           vel_side: nb_vs_ff[k_ff]};
               phase_in = 1'b1;
               state_in = ST_ROTATE;
            end
         end
         ST_MUL_XX: state_in = ST_MUL_YY;
         ST_MUL_YY: begin
            d2_in = prod_ff[59:0];
            state_in = ST_MUL_XV;
         end
         ST_MUL_XV: begin
            d2_in = d2_ff + prod_ff[59:0];
            state_in = ST_MUL_YV;
         end
         ST_MUL_YV: begin
            dot_in = prod_ff[55:0];
            state_in = ST_MUL_END;
         end
         ST_MUL_END: begin
            dot_in = dot_ff + prod_ff[55:0];
            rd_cmd.root = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: if (rd_done) state_in = ST_JUDGE;
         ST_JUDGE: begin
            state_in = ST_CHOOSE;
            if (moving) begin
               // quotient would not fit in the time field
               if ({3'b0, d2_ff} >= a128) t_in = T_MAX;
               else begin
                  rd_cmd.div = 1'b1;
                  state_in = ST_DIVIDE;
               end
            end else if (d2_ff < {28'b0, m2}) begin
               t_in = 20'd1;
            end else begin
               t_in = (t400 > {20'b0, T_MAX}) ? T_MAX : t400[19:0];
            end
         end
         ST_DIVIDE: begin
            if (rd_done) begin
               t_in = rd_quot;
               state_in = ST_CHOOSE;
            end
         end
         ST_CHOOSE: begin
            if (!k_ff && (t_ff > thr_ff) && seen_ff) begin
               k_in = 1'b1;
               state_in = ST_NB_CHECK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_t_in = t_ff;
               rsp_col_in = col;
               rsp_sh_in = mode_ff && col && (lo18 < tz18) && (hi18 > tz18);
               if (mode_ff && col && (lo18 < tz18) && (hi18 > tz18)) begin
                  if (cz18 > 18'sd32767) rsp_cz_in = 16'sh7FFF;
                  else if (cz18 < -18'sd32768) rsp_cz_in = 16'sh8000;
                  else rsp_cz_in = cz18[15:0];
                  rsp_cr_in = $signed(cr16);
               end else begin
                  rsp_cz_in = tz_ff;
                  rsp_cr_in = 16'sd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff    <= 20'd640;
         mind_ff   <= 16'd128;
         cruise_ff <= 16'sd192;
         band_ff   <= 15'd64;
         vnum_ff   <= 3'd2;
         en_ff     <= 1'b1;
         seen_ff   <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            nb_x_ff[i]  <= '0;
            nb_y_ff[i]  <= '0;
            nb_hd_ff[i] <= '0;
            nb_vf_ff[i] <= '0;
            nb_vs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TIME_THRESHOLD:   thr_ff    <= csr_data;
               CSR_MINIMUM_DISTANCE: mind_ff   <= csr_data[15:0];
               CSR_CRUISE_ALTITUDE:  cruise_ff <= csr_data[15:0];
               CSR_BAND_HALF_WIDTH:  band_ff   <= csr_data[14:0];
               CSR_VEHICLE_NUMBER:   vnum_ff   <= csr_data[2:0];
               CSR_AVOID_ENABLE:     en_ff     <= csr_data[0];
               default: ;
            endcase
         end
         if (nb_write) begin
            nb_x_ff[nb_idx]  <= req_pos_x;
            nb_y_ff[nb_idx]  <= req_pos_y;
            nb_hd_ff[nb_idx] <= req_heading;
            nb_vf_ff[nb_idx] <= req_vel_forward;
            nb_vs_ff[nb_idx] <= req_vel_side;
            if (nb_idx) seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      tz_ff <= tz_in;
      mode_ff <= mode_in;
      k_ff <= k_in;
      phase_ff <= phase_in;
      swx_ff <= swx_in;
      swy_ff <= swy_in;
      nwx_ff <= nwx_in;
      nwy_ff <= nwy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      d2_ff <= d2_in;
      dot_ff <= dot_in;
      prod_ff <= product;
      t_ff <= t_in;
      rsp_t_ff <= rsp_t_in;
      rsp_col_ff <= rsp_col_in;
      rsp_sh_ff <= rsp_sh_in;
      rsp_cz_ff <= rsp_cz_in;
      rsp_cr_ff <= rsp_cr_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_time_to_hit = rsp_t_ff;
   assign rsp_collide     = rsp_col_ff;
   assign rsp_shifted     = rsp_sh_ff;
   assign rsp_cmd_z       = rsp_cz_ff;
   assign rsp_climb_rate  = rsp_cr_ff;

endmodule

### rtl/ttca_checker.sv
`include "time_to_collision_avoider_assert.svh"

module ttca_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_collide,
   input logic               rsp_shifted,
   input logic signed [15:0] rsp_climb_rate
);

   `TTCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `TTCA_ASSERT_NOW(a_shift_needs_collide, rsp_valid && rsp_shifted, rsp_collide, "shift without collision")
   `TTCA_ASSERT_NOW(a_climb_idle, rsp_valid && !rsp_shifted, rsp_climb_rate == 16'sd0, "climb rate without shift")
   `TTCA_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid, "response straight after reset")

endmodule

bind time_to_collision_avoider ttca_checker u_ttca_checker (.*);
